// ----- hw/rtl/sida_pkg.sv -----
`timescale 1ns / 1ps

package sida_pkg;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] char_t;

  localparam digit_t BCD_ADJ_MIN = 4'd5;
  localparam digit_t BCD_ADJ_ADD = 4'd3;

  localparam char_t CHAR_ZERO  = 8'd48;
  localparam char_t CHAR_NINE  = 8'd57;
  localparam char_t CHAR_MINUS = 8'd45;

endpackage

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// A word is accepted when start is seen while idle. The shift-add-3 loop converts its magnitude one
// bit per cycle; a negative value's minus sign is then driven, and the digit scan drives the digits
// from the most significant, skipping leading zeros. busy stays high until the digit scan ends, so no
// new word is accepted before the current word has been converted and its digits scanned.
// Reset is synchronous and active low; it returns the sequencer to idle and clears the strobe.
// Results cannot be stalled: each character is shown for exactly one cycle.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output sida_pkg::char_t       out_char_code,
  output logic                  out_last_char
);
  import sida_pkg::*;

  localparam int NDIG   = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int CONV_W = $clog2(VALUE_BITS);
  localparam int DIG_W  = $clog2(NDIG);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  state_t              state_r, state_nxt;
  logic [NDIG*4-1:0]   bcd_r, bcd_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic                started_r, started_nxt;
  logic [CONV_W-1:0]   conv_cnt_r, conv_cnt_nxt;
  logic [DIG_W-1:0]    dig_cnt_r, dig_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  char_t               out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic [NDIG*4-1:0]     bcd_step;
  logic [VALUE_BITS-1:0] mag_step;
  digit_t                top_digit;

  sida_dabble #(
    .NDIG (NDIG),
    .VB   (VALUE_BITS)
  ) u_dabble (
    .bcd_cur  (bcd_r),
    .mag_cur  (mag_r),
    .bcd_next (bcd_step),
    .mag_next (mag_step)
  );

  assign top_digit = bcd_r[NDIG*4-1 -: 4];

  always_comb begin
    state_nxt     = state_r;
    bcd_nxt       = bcd_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    conv_cnt_nxt  = conv_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt      = in_value[VALUE_BITS-1];
          mag_nxt      = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
          bcd_nxt      = '0;
          started_nxt  = 1'b0;
          conv_cnt_nxt = CONV_W'(VALUE_BITS - 1);
          dig_cnt_nxt  = DIG_W'(NDIG - 1);
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt      = bcd_step;
        mag_nxt      = mag_step;
        conv_cnt_nxt = conv_cnt_r - 1'b1;
        if (conv_cnt_r == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = CHAR_MINUS;
        out_last_nxt  = 1'b0;
        state_nxt     = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (started_r || (top_digit != '0) || (dig_cnt_r == '0)) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {4'b0000, top_digit};
          out_last_nxt  = (dig_cnt_r == '0);
          started_nxt   = 1'b1;
        end
        bcd_nxt     = {bcd_r[NDIG*4-5:0], 4'b0000};
        dig_cnt_nxt = dig_cnt_r - 1'b1;
        if (dig_cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bcd_r      <= bcd_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    started_r  <= started_nxt;
    conv_cnt_r <= conv_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule

// ----- hw/rtl/sida_dabble.sv -----
`timescale 1ns / 1ps

module sida_dabble #(
  parameter int NDIG = 10,
  parameter int VB   = 32
) (
  input  logic [NDIG*4-1:0] bcd_cur,
  input  logic [VB-1:0]     mag_cur,
  output logic [NDIG*4-1:0] bcd_next,
  output logic [VB-1:0]     mag_next
);
  import sida_pkg::*;

  logic [NDIG*4-1:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_cur[i*4 +: 4] >= BCD_ADJ_MIN) begin
        bcd_adj[i*4 +: 4] = bcd_cur[i*4 +: 4] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_cur[i*4 +: 4];
      end
    end
  end

  assign bcd_next = {bcd_adj[NDIG*4-2:0], mag_cur[VB-1]};
  assign mag_next = {mag_cur[VB-2:0], 1'b0};

endmodule

// ----- hw/rtl/sida_checker.sv -----
`timescale 1ns / 1ps

module sida_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input sida_pkg::char_t out_char_code,
  input logic            out_last_char
);
  import sida_pkg::*;

  // A new word starts the conversion loop, so no character can follow it directly.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted word did not start a conversion");

  a_inner_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_char) |-> busy)
    else $error("non-final character shown while idle");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char) |-> !busy)
    else $error("final character shown while still busy");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code == CHAR_MINUS) ||
                   ((out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_NINE))))
    else $error("character outside sign and digit set");

  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char) |-> (out_char_code != CHAR_MINUS))
    else $error("word ended on a sign character");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_char_code (out_char_code),
  .out_last_char (out_last_char)
);

// ----- bench/signed_int_to_decimal_ascii_tb.sv -----
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

  import sida_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int RANDOM_WORDS = 400;
  localparam int CALM_FROM = 6000;
  localparam int CALM_TO = 10000;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 300000;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    char_t code;
    logic  last;
  } char_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  value_t in_value = '0;
  logic out_valid;
  char_t out_char_code;
  logic out_last_char;

  value_t pending_values[$];
  char_rec_t expected_chars[$];
  int total_words = 0;
  int words_taken = 0;
  int chars_checked = 0;
  int negatives_taken = 0;
  int errors = 0;
  int cycles = 0;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  always #5 clk = ~clk;

  // Appends the decimal text of one signed word to the queue of expected characters.
  function automatic void spell_decimal(value_t v);
    value_t mag;
    char_t digits[$];
    char_rec_t rec;
    if (v == '0) begin
      rec.code = CHAR_ZERO;
      rec.last = 1'b1;
      expected_chars.push_back(rec);
      return;
    end
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    while (mag != '0) begin
      digits.push_front(CHAR_ZERO + char_t'(mag % 10));
      mag = mag / 10;
    end
    if (v[VALUE_BITS-1]) begin
      negatives_taken++;
      rec.code = CHAR_MINUS;
      rec.last = 1'b0;
      expected_chars.push_back(rec);
    end
    foreach (digits[i]) begin
      rec.code = digits[i];
      rec.last = (i == digits.size() - 1);
      expected_chars.push_back(rec);
    end
  endfunction

  function automatic value_t pick_value();
    value_t v;
    int unsigned lo;
    int unsigned hi;
    int d;
    case ($urandom_range(3))
      0: v = $urandom;
      1: begin
        d = $urandom_range(1, 9);
        lo = 1;
        repeat (d - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        v = $urandom_range(hi, (d == 1) ? 0 : lo);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      2: begin
        lo = 1;
        repeat ($urandom_range(0, 9)) lo = lo * 10;
        v = lo + $urandom_range(2) - 1;
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      default: begin
        if ($urandom_range(1)) v = 32'h8000_0000 + $urandom_range(3);
        else v = 32'h7fff_ffff - $urandom_range(3);
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words taken and %0d characters outstanding",
               $time, words_taken, expected_chars.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : driver
    logic accepted;
    logic calm;
    accepted = rst_n && start && !busy;
    calm = (cycles >= CALM_FROM) && (cycles < CALM_TO);
    if (accepted) begin
      spell_decimal(in_value);
      words_taken++;
    end
    if (!rst_n) begin
      start <= 1'b0;
    end else if (accepted || !start) begin
      if (pending_values.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
        in_value <= pending_values.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    char_rec_t want;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                 $time, out_char_code, out_last_char);
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_char_code !== want.code) begin
          errors++;
          $display("%0t: char_code mismatch: expected %0d, actual %0d",
                   $time, want.code, out_char_code);
        end
        if (out_last_char !== want.last) begin
          errors++;
          $display("%0t: last_char mismatch: expected %0b, actual %0b",
                   $time, want.last, out_last_char);
        end
      end
    end
  end

  initial begin
    value_t directed[$];
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd1000000000, -32'sd999999999, 32'd12345,
                 -32'sd99999, 32'haaaa_aaaa, 32'h5555_5555, 32'd4294967286};
    foreach (directed[i]) pending_values.push_back(directed[i]);
    for (int i = 0; i < RANDOM_WORDS; i++) pending_values.push_back(pick_value());
    total_words = pending_values.size();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (words_taken == total_words);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d words (%0d negative), checked %0d characters in %0d cycles.",
             words_taken, negatives_taken, chars_checked, cycles);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
